>>> sv/mrct_pkg.sv
// ----------------------------------------------------------------------------
// mrct_pkg: shared types and constants of the memory read cycle tracer
// Field widths, stream packing, command codes, tracker states and the
// structs passed between the tracker and the trace memory.
// ----------------------------------------------------------------------------
package mrct_pkg;

  // field widths
  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned LenW      = 16;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned CntOutW   = 11;
  localparam int unsigned DelayW    = 8;

  // default trace depth and register reset value
  localparam int unsigned DepthDefault = 1024;
  localparam logic [DelayW-1:0] DelayReset = 8'd3;

  // stream widths, padded to whole bytes
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 56;

  // command carried on tuser
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  // read cycle tracker states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WAIT  = 3'b010,
    ST_COUNT = 3'b100
  } trk_state_e;

  // one sampled bus beat as seen by the tracker
  typedef struct packed {
    logic             tick;
    logic             active;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } sample_t;

  // one trace entry as held in memory
  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [DataW-1:0] data;
    logic [AddrW-1:0] addr;
  } trace_entry_t;

  // write request from the tracker to the trace memory
  typedef struct packed {
    logic         we;
    trace_entry_t entry;
  } wr_req_t;

endpackage

>>> sv/mrct_trace_mem.sv
// ----------------------------------------------------------------------------
// mrct_trace_mem: trace entry memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrct_trace_mem #(
  parameter int unsigned Depth = mrct_pkg::DepthDefault,
  parameter int unsigned AW    = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  mrct_pkg::trace_entry_t wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output mrct_pkg::trace_entry_t rdata_o
);

  mrct_pkg::trace_entry_t mem [Depth];
  mrct_pkg::trace_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mrct_tracker.sv
// ----------------------------------------------------------------------------
// mrct_tracker: memory read cycle tracker
// Follows the strobes tick by tick, latches address and data, counts the
// cycle length and issues one trace write per finished cycle.
// ----------------------------------------------------------------------------
module mrct_tracker #(
  parameter int unsigned Depth = mrct_pkg::DepthDefault,
  parameter int unsigned CW    = $clog2(Depth + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mrct_pkg::DelayW-1:0]   cfg_wdata_i,
  input  mrct_pkg::sample_t             smp_i,
  output mrct_pkg::wr_req_t             wr_o,
  output logic [CW-1:0]                 count_o,
  output logic                          in_cycle_o,
  output logic                          full_o
);

  mrct_pkg::trk_state_e              state_q, state_d;
  logic [CW-1:0]                     count_q, count_d;
  logic [mrct_pkg::LenW-1:0]         tick_q, tick_d, tick_inc;
  logic [mrct_pkg::AddrW-1:0]        addr_q, addr_d;
  logic [mrct_pkg::DataW-1:0]        data_q, data_d;
  logic [mrct_pkg::DelayW-1:0]       delay_q;
  logic                              full;

  assign full     = (count_q == CW'(Depth));
  assign tick_inc = tick_q + mrct_pkg::LenW'(1);

  // next state of the tracker
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    tick_d         = tick_q;
    addr_d         = addr_q;
    data_d         = data_q;
    wr_o.we        = 1'b0;
    wr_o.entry.addr = addr_q;
    wr_o.entry.data = data_q;
    wr_o.entry.len  = '0;
    if (smp_i.tick && !full) begin
      case (state_q)
        mrct_pkg::ST_IDLE: begin
          if (smp_i.active) begin
            addr_d  = smp_i.addr;
            data_d  = smp_i.data;
            tick_d  = '0;
            state_d = (delay_q == '0) ? mrct_pkg::ST_COUNT : mrct_pkg::ST_WAIT;
          end
        end
        mrct_pkg::ST_WAIT: begin
          if (smp_i.active) begin
            data_d = smp_i.data;
            if (tick_inc >= mrct_pkg::LenW'(delay_q)) begin
              state_d = mrct_pkg::ST_COUNT;
              tick_d  = '0;
            end else begin
              tick_d = tick_inc;
            end
          end else begin
            // cycle ended before the data point: zero length
            wr_o.we = 1'b1;
            count_d = count_q + CW'(1);
            tick_d  = '0;
            state_d = mrct_pkg::ST_IDLE;
          end
        end
        mrct_pkg::ST_COUNT: begin
          if (smp_i.active) begin
            if (tick_q != '1) begin
              tick_d = tick_inc;
            end
          end else begin
            wr_o.we        = 1'b1;
            wr_o.entry.len = tick_q;
            count_d        = count_q + CW'(1);
            tick_d         = '0;
            state_d        = mrct_pkg::ST_IDLE;
          end
        end
        default: begin
          state_d = mrct_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // tracker registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrct_pkg::ST_IDLE;
      count_q <= '0;
      tick_q  <= '0;
      addr_q  <= '0;
      data_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      tick_q  <= tick_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
    end
  end

  // sample delay register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= mrct_pkg::DelayReset;
    end else if (cfg_we_i) begin
      delay_q <= cfg_wdata_i;
    end
  end

  assign count_o    = count_q;
  assign in_cycle_o = (state_q != mrct_pkg::ST_IDLE);
  assign full_o     = full;

endmodule

>>> sv/memory_read_cycle_tracer_top.sv
// ----------------------------------------------------------------------------
// memory_read_cycle_tracer_top: bus trace capture buffer
// Tracks processor memory read cycles from sampled strobes and stores
// address, data and length of each one; read beats return stored entries.
// ----------------------------------------------------------------------------
// channel   direction  tdata fields (lsb first)                         tuser
// s_axis    in         rd_n, mreq_n, bus_addr, bus_data, read_index     cmd
// m_axis    out        in_cycle, buffer_full, entry_count, entry_valid,  -
//                      entry_addr, entry_data, entry_len
// cfg       in         data_sample_delay (8 bits), written when cfg_we_i
//
// One beat per clock while the output side is ready; each result appears in the
// cycle after its input beat, as the trace memory read port is registered.
// A stalled result holds the input side until it is taken.
// Reset clears the tracker and entry count; the trace memory is not cleared
// and needs no sweep, entries at or past the count read as invalid.
// ----------------------------------------------------------------------------
module memory_read_cycle_tracer_top #(
  parameter int unsigned Depth = mrct_pkg::DepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config register
  input  logic                              cfg_we_i,
  input  logic [mrct_pkg::DelayW-1:0]       cfg_wdata_i,
  // input beats
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // rd_n[0], mreq_n[1], bus_addr[17:2], bus_data[25:18], read_index[35:26]
  input  logic [mrct_pkg::InTdataW-1:0]     s_axis_tdata,
  // cmd[0]
  input  logic                              s_axis_tuser,
  // result beats
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // in_cycle[0], buffer_full[1], entry_count[12:2], entry_valid[13],
  // entry_addr[29:14], entry_data[37:30], entry_len[53:38]
  output logic [mrct_pkg::OutTdataW-1:0]    m_axis_tdata
);

  localparam int unsigned AW   = $clog2(Depth);
  localparam int unsigned CW   = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CW > mrct_pkg::IdxW) ? CW : mrct_pkg::IdxW;

  logic                          accept;
  logic                          is_read;
  logic [mrct_pkg::IdxW-1:0]     read_index;
  mrct_pkg::sample_t             smp;
  mrct_pkg::wr_req_t             wr;
  mrct_pkg::trace_entry_t        rdata;
  mrct_pkg::trace_entry_t        entry;
  logic [CW-1:0]                 count;
  logic                          in_cycle;
  logic                          full;
  logic                          hit;
  logic                          res_valid_q;
  logic                          hit_q;

  // input beat decode
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign is_read    = (mrct_pkg::cmd_e'(s_axis_tuser) == mrct_pkg::CMD_READ);
  assign read_index = s_axis_tdata[35:26];

  assign smp.tick   = accept && !is_read;
  assign smp.active = !s_axis_tdata[0] && !s_axis_tdata[1];
  assign smp.addr   = s_axis_tdata[17:2];
  assign smp.data   = s_axis_tdata[25:18];

  // a read hits only entries below the fill count
  assign hit = is_read && (CmpW'(read_index) < CmpW'(count));

  mrct_tracker #(
    .Depth (Depth),
    .CW    (CW)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .smp_i       (smp),
    .wr_o        (wr),
    .count_o     (count),
    .in_cycle_o  (in_cycle),
    .full_o      (full)
  );

  mrct_trace_mem #(
    .Depth (Depth),
    .AW    (AW)
  ) u_trace_mem (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (count[AW-1:0]),
    .wdata_i (wr.entry),
    .re_i    (accept && is_read),
    .raddr_i (AW'(read_index)),
    .rdata_o (rdata)
  );

  // result stage, tracker status is stable while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q <= hit;
    end
  end

  assign s_axis_tready = !res_valid_q || m_axis_tready;

  // result beat packing
  assign entry = hit_q ? rdata : '0;

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {2'b00,
                          entry.len,
                          entry.data,
                          entry.addr,
                          hit_q,
                          mrct_pkg::CntOutW'(count),
                          full,
                          in_cycle};

endmodule
